// ----- rtl/assert_macros.svh -----
// Assertion macros for the top-level RTL file of the median filter.
// Depends on nothing; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: invariant");
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/mf3_pkg.sv -----
// Package of the 3x3 median filter: sizes, register indexes, shared types
// and the small compare functions of the median network. No dependencies.
package mf3_pkg;

  localparam int MaxWidth   = 1024;
  localparam int LineAw     = $clog2(MaxWidth);
  localparam int PixW       = 8;
  localparam int RowW       = 12;
  localparam int ColW       = 10;
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 13;
  localparam int CfgIdxW    = 2;
  localparam int FifoDepth  = 8;
  localparam int FifoAw     = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;
  localparam int MinDim      = 3;
  localparam int MaxHeight   = 4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageHeight = CfgIdxW'(1);

  typedef logic [PixW-1:0] pix_t;

  // Position tags carried along with a pixel.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } tag_t;

  // One result transaction.
  typedef struct packed {
    pix_t median;
    tag_t tag;
  } res_t;

  // One accepted pixel as handed to the median pipeline.
  typedef struct packed {
    logic              vld;
    logic              emit;
    pix_t              px;
    logic [LineAw-1:0] addr;
    tag_t              tag;
  } item_t;

  // Line store write-back request: upper byte is the older row.
  typedef struct packed {
    logic              en;
    logic [LineAw-1:0] addr;
    logic [2*PixW-1:0] data;
  } wb_t;

  // A column of three values in ascending order.
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } trio_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(pix_t a, pix_t b, pix_t c);
    trio_t r;
    r.lo = min2(min2(a, b), c);
    r.hi = max2(max2(a, b), c);
    r.md = med3(a, b, c);
    return r;
  endfunction

endpackage

// ----- rtl/mf3_line_store.sv -----
// Line store of the median filter: both previous rows packed in one
// synchronous RAM word per column. Depends on mf3_pkg.
module mf3_line_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [mf3_pkg::LineAw-1:0] rd_addr_i,
  input  mf3_pkg::wb_t              wb_i,
  output logic [2*mf3_pkg::PixW-1:0] rd_data_o
);
  import mf3_pkg::*;

  logic [2*PixW-1:0] mem [MaxWidth];
  logic [2*PixW-1:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wb_i.en) begin
      mem[wb_i.addr] <= wb_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/mf3_median_pipe.sv -----
// Window registers, line store write-back and the three-stage median
// network of the filter. Depends on mf3_pkg.
module mf3_median_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mf3_pkg::item_t            item_i,
  input  logic [2*mf3_pkg::PixW-1:0] rd_data_i,
  output mf3_pkg::wb_t              wb_o,
  output logic                      res_vld_o,
  output mf3_pkg::res_t             res_o
);
  import mf3_pkg::*;

  // Stage 1: pixel waiting for its line store read data.
  logic              s1_vld_q, s1_emit_q;
  pix_t              s1_px_q;
  logic [LineAw-1:0] s1_addr_q;
  tag_t              s1_tag_q;
  pix_t              win_q [6];

  // Stage 2: sorted columns. Stage 3: the three partial medians.
  logic  s2_vld_q, s3_vld_q;
  trio_t s2_col_q [3];
  tag_t  s2_tag_q, s3_tag_q;
  pix_t  s3_a_q, s3_b_q, s3_c_q;

  pix_t  top, mid;
  trio_t col_srt [3];

  assign top = rd_data_i[2*PixW-1:PixW];
  assign mid = rd_data_i[PixW-1:0];

  // Column sort over the two window columns and the incoming column.
  always_comb begin
    col_srt[0] = sort3(win_q[0], win_q[1], win_q[2]);
    col_srt[1] = sort3(win_q[3], win_q[4], win_q[5]);
    col_srt[2] = sort3(top, mid, s1_px_q);
  end

  // The row above moves down one slot and the new pixel takes its place.
  assign wb_o.en   = s1_vld_q;
  assign wb_o.addr = s1_addr_q;
  assign wb_o.data = {mid, s1_px_q};

  // Control flags of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_emit_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
    end else begin
      s1_vld_q  <= item_i.vld;
      s1_emit_q <= item_i.emit;
      s2_vld_q  <= s1_vld_q && s1_emit_q;
      s3_vld_q  <= s2_vld_q;
    end
  end

  // Window shifts once per pixel: oldest column drops out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_vld_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_px_q;
    end
  end

  // Payload of the stages.
  always_ff @(posedge clk_i) begin
    if (item_i.vld) begin
      s1_px_q   <= item_i.px;
      s1_addr_q <= item_i.addr;
      s1_tag_q  <= item_i.tag;
    end
    for (int i = 0; i < 3; i++) begin
      s2_col_q[i] <= col_srt[i];
    end
    s2_tag_q <= s1_tag_q;
    // Max of the lows, median of the middles, min of the highs.
    s3_a_q   <= max2(max2(s2_col_q[0].lo, s2_col_q[1].lo), s2_col_q[2].lo);
    s3_b_q   <= med3(s2_col_q[0].md, s2_col_q[1].md, s2_col_q[2].md);
    s3_c_q   <= min2(min2(s2_col_q[0].hi, s2_col_q[1].hi), s2_col_q[2].hi);
    s3_tag_q <= s2_tag_q;
  end

  // The median of the nine is the median of the three partial results.
  assign res_vld_o    = s3_vld_q;
  assign res_o.median = med3(s3_a_q, s3_b_q, s3_c_q);
  assign res_o.tag    = s3_tag_q;

endmodule

// ----- rtl/mf3_out_fifo.sv -----
// Output queue of the median filter; it decouples the fixed-latency median
// pipeline from the result channel. Depends on mf3_pkg.
module mf3_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  mf3_pkg::res_t                 push_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mf3_pkg::res_t                 out_data_o
);
  import mf3_pkg::*;

  res_t              buf_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = buf_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      cnt_q <= cnt_q + FifoCntW'(push_i) - FifoCntW'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/median_filter_3x3_unit.sv -----
// Top level of the 3x3 median filter: frame counters, configuration
// registers and result credit. Depends on mf3_pkg, assert_macros.svh and the three sub-modules.
//
//   channel  direction  signals                                  payload
//   cfg      in         cfg_valid_i / cfg_ready_o                cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_ready_o                  pixel_i
//   out      out        out_valid_o / out_ready_i                median_value_o, centre_*_o, frame_last_o
//
// One pixel per cycle is taken while in_ready_o is high; out_valid_o rises once its median is queued.
// The line store is one RAM word per column read at accept and written back in the following cycle.
// Up to eight results may be outstanding; in_ready_o drops while eight are in flight or queued.
// Reset restores 640 x 480 and row/column zero; line stores keep no reset value.
// The configuration port is always ready; a write to a known register restarts the frame.
`include "assert_macros.svh"

module median_filter_3x3_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mf3_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mf3_pkg::CfgHeightW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mf3_pkg::PixW-1:0]       pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mf3_pkg::PixW-1:0]       median_value_o,
  output logic [mf3_pkg::RowW-1:0]       centre_row_o,
  output logic [mf3_pkg::ColW-1:0]       centre_col_o,
  output logic                           frame_last_o
);
  import mf3_pkg::*;

  logic [CfgWidthW-1:0]  width_q, w_eff;
  logic [CfgHeightW-1:0] height_q, h_eff;
  logic [RowW-1:0]       row_q;
  logic [ColW-1:0]       col_q;
  logic [FifoCntW-1:0]   pend_q;
  logic                  in_fire, out_fire, emit, restart;
  logic [CfgWidthW-1:0]  col_inc;
  logic [CfgHeightW-1:0] row_inc;
  item_t                 item;
  wb_t                   wb;
  logic [2*PixW-1:0]     rd_data;
  logic                  res_vld;
  res_t                  res, out_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (pend_q < FifoCntW'(FifoDepth));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Effective frame size after clamping.
  always_comb begin
    if (width_q < CfgWidthW'(MinDim)) begin
      w_eff = CfgWidthW'(MinDim);
    end else if (width_q > CfgWidthW'(MaxWidth)) begin
      w_eff = CfgWidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < CfgHeightW'(MinDim)) begin
      h_eff = CfgHeightW'(MinDim);
    end else if (height_q > CfgHeightW'(MaxHeight)) begin
      h_eff = CfgHeightW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end
  end

  // Position arithmetic of the incoming pixel.
  assign col_inc = CfgWidthW'(col_q) + CfgWidthW'(1);
  assign row_inc = CfgHeightW'(row_q) + CfgHeightW'(1);
  assign emit    = (row_q >= RowW'(2)) && (col_q >= ColW'(2));

  always_comb begin
    item.vld      = in_fire;
    item.emit     = emit;
    item.px       = pixel_i;
    item.addr     = col_q[LineAw-1:0];
    item.tag.row  = row_q - RowW'(1);
    item.tag.col  = col_q - ColW'(1);
    item.tag.last = (row_inc == h_eff) && (col_inc == w_eff);
  end

  // Register writes to a known index restart the frame.
  always_comb begin
    restart = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  restart = 1'b1;
        RegImageHeight: restart = 1'b1;
        default:        restart = 1'b0;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(ResetWidth);
      height_q <= CfgHeightW'(ResetHeight);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  width_q  <= cfg_data_i[CfgWidthW-1:0];
        RegImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Raster counters and the count of results not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      pend_q <= '0;
    end else begin
      if (restart) begin
        row_q <= '0;
        col_q <= '0;
      end else if (in_fire) begin
        if (col_inc >= w_eff) begin
          col_q <= '0;
          if (row_inc >= h_eff) begin
            row_q <= '0;
          end else begin
            row_q <= row_inc[RowW-1:0];
          end
        end else begin
          col_q <= col_inc[ColW-1:0];
        end
      end
      pend_q <= pend_q + FifoCntW'(in_fire && emit) - FifoCntW'(out_fire);
    end
  end

  mf3_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q[LineAw-1:0]),
    .wb_i      (wb),
    .rd_data_o (rd_data)
  );

  mf3_median_pipe u_median_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .rd_data_i (rd_data),
    .wb_o      (wb),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  mf3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign median_value_o = out_res.median;
  assign centre_row_o   = out_res.tag.row;
  assign centre_col_o   = out_res.tag.col;
  assign frame_last_o   = out_res.tag.last;

  // The column counter never leaves the current frame width.
  `ASSERT_ALWAYS(a_col_in_frame, clk_i, rst_ni, CfgWidthW'(col_q) < w_eff)
  // Outstanding results never exceed the queue depth.
  `ASSERT_ALWAYS(a_pend_bound, clk_i, rst_ni, pend_q <= FifoCntW'(FifoDepth))
  // A result is only offered while one is outstanding.
  `ASSERT_IMPL(a_out_has_credit, clk_i, rst_ni, out_valid_o, pend_q != '0)
  // Accepting a border-free pixel leaves at least one result outstanding.
  `ASSERT_NEXT(a_emit_counted, clk_i, rst_ni, in_fire && emit, pend_q != '0)

endmodule

// ----- tb/median_filter_3x3_unit_tb.sv -----
// Self-checking testbench for median_filter_3x3_unit: streams pixel frames and
// checks every median transaction against a local predictor of the filter.
// Depends on mf3_pkg and the median_filter_3x3_unit RTL.
module median_filter_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] RegSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareHi = CfgIdxW'(3);

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPixels = 330;
  localparam int unsigned TallRows     = 40;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned ShownErrors  = 40;

  // One expected median transaction.
  typedef struct packed {
    pix_t            median;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } median_exp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index = '0;
  logic [CfgHeightW-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pix_t                  pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pix_t                  median_value;
  logic [RowW-1:0]       centre_row;
  logic [ColW-1:0]       centre_col;
  logic                  frame_last;

  // Predictor state: registers, line stores, window and raster position.
  logic [CfgWidthW-1:0]  width_reg = CfgWidthW'(ResetWidth);
  logic [CfgHeightW-1:0] height_reg = CfgHeightW'(ResetHeight);
  pix_t                  row_above [MaxWidth];
  pix_t                  row_above2 [MaxWidth];
  pix_t [5:0]            window_cols = '0;
  int unsigned           row_pos = 0;
  int unsigned           col_pos = 0;

  median_exp_t pending_medians [$];

  bit          idle_on = 1'b1;
  int unsigned stall_cnt = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned medians_checked = 0;
  int unsigned geometry_writes = 0;

  median_filter_3x3_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .median_value_o (median_value),
    .centre_row_o   (centre_row),
    .centre_col_o   (centre_col),
    .frame_last_o   (frame_last)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register value as the block uses it, held between three and the limit.
  function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned hi);
    if (raw < MinDim) return MinDim;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Fifth smallest of nine: the value with at most four below it and at
  // least five at or below it.
  function automatic pix_t median_of_nine(input pix_t [8:0] vals);
    int below;
    int atmost;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      atmost = 0;
      for (int j = 0; j < 9; j++) begin
        if (vals[j] < vals[i]) below++;
        if (vals[j] <= vals[i]) atmost++;
      end
      if (below <= 4 && atmost >= 5) return vals[i];
    end
    return vals[0];
  endfunction

  // Advance the predictor by one accepted pixel and queue its median, if any.
  task automatic predict_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    pix_t        up2;
    pix_t        up1;
    pix_t [8:0]  hood;
    median_exp_t exp_med;
    w = eff_dim(width_reg, MaxWidth);
    h = eff_dim(height_reg, MaxHeight);
    up2 = row_above2[col_pos];
    up1 = row_above[col_pos];
    row_above2[col_pos] = up1;
    row_above[col_pos] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      hood = {px, up1, up2, window_cols};
      exp_med.median = median_of_nine(hood);
      exp_med.row = RowW'(row_pos - 1);
      exp_med.col = ColW'(col_pos - 1);
      exp_med.last = (row_pos + 1 == h) && (col_pos + 1 == w);
      pending_medians.push_back(exp_med);
    end
    window_cols = {px, up1, up2, window_cols[5:3]};
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Send one pixel transaction after a random gap (none while idle_on is clear) and update the predictor.
  task automatic push_pixel(input pix_t px);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk_i); while (!in_ready);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // Stop sending, let every expected median arrive, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One configuration write while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgHeightW-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Known registers restart the frame; spare indexes change nothing.
    if (idx == RegImageWidth || idx == RegImageHeight) begin
      if (idx == RegImageWidth) width_reg = data[CfgWidthW-1:0];
      else height_reg = data;
      row_pos = 0;
      col_pos = 0;
      geometry_writes++;
    end
  endtask

  task automatic set_geometry(input logic [CfgHeightW-1:0] w_data,
                              input logic [CfgHeightW-1:0] h_data);
    write_reg(RegImageWidth, w_data);
    write_reg(RegImageHeight, h_data);
  endtask

  // Nine pixels in raster order; the first one is the leftmost in the literal.
  task automatic push_frame9(input pix_t [8:0] vals);
    for (int i = 8; i >= 0; i--) push_pixel(vals[i]);
  endtask

  task automatic push_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_pixel(pix_t'($urandom_range(0, 255)));
  endtask

  // Pixel content: fully random, only black and white, or a narrow band full of ties.
  function automatic pix_t next_pixel(input int unsigned style, input pix_t base);
    case (style)
      0: return pix_t'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? pix_t'(255) : pix_t'(0);
      default: return pix_t'(base + $urandom_range(0, 3));
    endcase
  endfunction

  // Compare one field of a median transaction.
  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= ShownErrors)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Receiver pacing: after each transaction, ready may drop for a random stall while idle_on is set.
  always @(posedge clk_i or negedge rst_ni) begin : rx_pace
    int unsigned hold;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else if (out_valid && out_ready) begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      stall_cnt <= hold;
      out_ready <= (hold == 0);
    end else if (stall_cnt > 1) begin
      stall_cnt <= stall_cnt - 1;
    end else begin
      stall_cnt <= 0;
      out_ready <= 1'b1;
    end
  end

  // Check each accepted median against the oldest expectation.
  always @(posedge clk_i) begin : check_medians
    median_exp_t exp_med;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_medians.size() == 0) begin
        error_count++;
        if (error_count <= ShownErrors)
          $display("%0t: median transaction with none expected: expected none, actual %0d at (%0d, %0d)",
                   $time, median_value, centre_row, centre_col);
      end else begin
        exp_med = pending_medians.pop_front();
        check_field("median_value", exp_med.median, median_value);
        check_field("centre_row", exp_med.row, centre_row);
        check_field("centre_col", exp_med.col, centre_col);
        check_field("frame_last", exp_med.last, frame_last);
        medians_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d medians outstanding.",
             cycle_count, pending_medians.size());
    $display("TB_ERROR");
    $finish;
  end

  // Reset geometry: part of the first row at 640 columns, which must give no median.
  task automatic test_reset_geometry();
    push_random(ResetWidth / 8);
  endtask

  // Smallest frames: one median each, flagged as the last; the second frame
  // checks the wrap back to row zero.
  task automatic test_min_frame();
    set_geometry(CfgHeightW'(3), CfgHeightW'(3));
    push_frame9({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    push_frame9({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
  endtask

  // Width of zero (upper data bits set, which the width register drops) and a
  // height of two are both taken as three.
  task automatic test_clamped_low();
    set_geometry(CfgHeightW'(13'h1800), CfgHeightW'(2));
    push_frame9({8'd128, 8'd1, 8'd64, 8'd2, 8'd32, 8'd4, 8'd16, 8'd8, 8'd255});
  endtask

  // Width register all ones is taken as the widest row; part of its first
  // row must stay free of medians.
  task automatic test_widest_frame();
    set_geometry(CfgHeightW'(13'h1FFF), CfgHeightW'(3));
    push_random(MaxWidth / 32);
  endtask

  // Height register all ones is taken as the tallest frame; a tall frame of
  // three columns, cut short, runs back to back.
  task automatic test_tallest_frame();
    idle_on = 1'b0;
    set_geometry(CfgHeightW'(3), CfgHeightW'(13'h1FFF));
    push_random(3 * TallRows);
    idle_on = 1'b1;
  endtask

  // Writes to unused indexes in the middle of a frame must not restart it.
  task automatic test_spare_index();
    set_geometry(CfgHeightW'(5), CfgHeightW'(6));
    push_random(13);
    write_reg(RegSpareLo, CfgHeightW'($urandom_range(0, 8191)));
    push_random(9);
    write_reg(RegSpareHi, CfgHeightW'($urandom_range(0, 8191)));
    push_random(8);
  endtask

  // A write in the middle of a frame restarts it even with the same value.
  task automatic test_restart_midframe();
    set_geometry(CfgHeightW'(4), CfgHeightW'(5));
    push_random(11);
    write_reg(RegImageHeight, CfgHeightW'(5));
    push_random(20);
  endtask

  // Random geometries and frames, mostly small and complete, some partial,
  // some out of range and some very tall ones cut short.
  task automatic test_random_frames();
    int unsigned        raw_w;
    int unsigned        raw_h;
    int unsigned        w;
    int unsigned        h;
    int unsigned        count;
    int unsigned        style;
    int unsigned        spare_at;
    int unsigned        sent;
    logic [CfgIdxW-1:0] spare_idx;
    pix_t               base;
    sent = 0;
    while (sent < RandomPixels) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       raw_w = $urandom_range(0, 2);
        1:       raw_w = $urandom_range(13, 40);
        default: raw_w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0, 1:    raw_h = $urandom_range(0, 2);
        2:       raw_h = $urandom_range(9, 8191);
        default: raw_h = $urandom_range(3, 8);
      endcase
      // Width data carries random upper bits, which the register drops.
      case ($urandom_range(0, 3))
        0: set_geometry({2'($urandom_range(0, 3)), 11'(raw_w)}, CfgHeightW'(raw_h));
        1: begin
          write_reg(RegImageHeight, CfgHeightW'(raw_h));
          write_reg(RegImageWidth, {2'($urandom_range(0, 3)), 11'(raw_w)});
        end
        2: write_reg(RegImageWidth, {2'($urandom_range(0, 3)), 11'(raw_w)});
        default: write_reg(RegImageHeight, CfgHeightW'(raw_h));
      endcase
      w = eff_dim(width_reg, MaxWidth);
      h = eff_dim(height_reg, MaxHeight);
      if (w * h > 400) count = w * $urandom_range(3, 6) + $urandom_range(0, w - 1);
      else begin
        count = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 1)) count += $urandom_range(0, w * h - 1);
      end
      // The last geometry only gets what is left of the pixel budget.
      if (count > RandomPixels - sent) count = RandomPixels - sent;
      style = $urandom_range(0, 2);
      base = pix_t'($urandom_range(0, 255));
      spare_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count - 1) : count;
      spare_idx = $urandom_range(0, 1) ? RegSpareLo : RegSpareHi;
      for (int unsigned i = 0; i < count; i++) begin
        if (i == spare_at) write_reg(spare_idx, CfgHeightW'($urandom_range(0, 8191)));
        push_pixel(next_pixel(style, base));
      end
      sent += count;
    end
    idle_on = 1'b1;
  endtask

  // Test sequence.
  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_min_frame();
    test_clamped_low();
    test_widest_frame();
    test_tallest_frame();
    test_spare_index();
    test_restart_midframe();
    test_random_frames();
    wait_idle();
    $display("Sent %0d pixels under %0d geometry writes and checked %0d medians,",
             pixels_sent, geometry_writes, medians_checked);
    $display("from 3x3 frames to clamped sizes, spare writes and a tall frame cut short.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
